// ===== hw/rtl/crdg_pkg.sv =====
// Shared constants, register codes and reset values of the camera ray direction generator.
`default_nettype none
package crdg_pkg;

    localparam int DEF_MAX_DIMENSION = 8192;

    localparam int COORD_W  = 13;  // pixel coordinate
    localparam int SIZE_W   = 14;  // surface size register
    localparam int SCALE_W  = 20;  // Q4.16 scale register
    localparam int VEC_W    = 63;  // three packed 21-bit components
    localparam int COMP_W   = 21;  // one packed component
    localparam int IDX_W    = 26;  // pixel index
    localparam int DIR_W    = 18;  // Q2.16 direction component
    localparam int NDC_FB   = 17;  // fraction bits of p / size
    localparam int DIR_FB   = 16;  // fraction bits of the normalize quotient
    localparam int UV_W     = 22;  // scaled coordinate, Q16
    localparam int PROD_W   = 43;  // u times axis component
    localparam int D_W      = 28;  // combined direction, Q19
    localparam int MAG_W    = 27;  // magnitude of one component
    localparam int SUM_W    = 54;  // sum of squares
    localparam int ROOT_W   = SUM_W / 2;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 144;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURFACE_WIDTH    = 3'd0,
        REG_SURFACE_HEIGHT   = 3'd1,
        REG_HORIZONTAL_SCALE = 3'd2,
        REG_VERTICAL_SCALE   = 3'd3,
        REG_RIGHT_AXIS       = 3'd4,
        REG_UP_AXIS          = 3'd5,
        REG_FORWARD_AXIS     = 3'd6,
        REG_CAMERA_POSITION  = 3'd7
    } t_cfg_reg;

    localparam logic [SIZE_W-1:0]  RST_WIDTH   = 14'd1280;
    localparam logic [SIZE_W-1:0]  RST_HEIGHT  = 14'd720;
    localparam logic [SCALE_W-1:0] RST_HSCALE  = 20'h10000;
    localparam logic [SCALE_W-1:0] RST_VSCALE  = 20'h10000;
    localparam logic [VEC_W-1:0]   RST_RIGHT   = 63'h0000_0000_0008_0000;
    localparam logic [VEC_W-1:0]   RST_UP      = 63'h0000_0100_0000_0000;
    localparam logic [VEC_W-1:0]   RST_FORWARD = 63'h6000_0000_0000_0000;
    localparam logic [VEC_W-1:0]   RST_CAMERA  = 63'h0028_0000_0000_0000;

endpackage
`default_nettype wire

// ===== hw/rtl/crdg_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, for numerators not above the divisor.
`default_nettype none
module crdg_div_pipe #(
    parameter int LANES = 1,
    parameter int W     = 8,
    parameter int FB    = 8,
    parameter int TAG_W = 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [LANES-1:0][W-1:0]       i_num,
    input  wire logic [LANES-1:0][W-1:0]       i_den,
    input  wire logic [TAG_W-1:0]              i_tag,
    output logic                               o_valid,
    output logic [LANES-1:0][FB:0]             o_quo,
    output logic [TAG_W-1:0]                   o_tag
);
    localparam int STAGES = FB + 1;

    logic             r_v   [STAGES];
    logic [W-1:0]     r_rem [STAGES][LANES];
    logic [W-1:0]     r_den [STAGES][LANES];
    logic [FB:0]      r_q   [STAGES][LANES];
    logic [TAG_W-1:0] r_tag [STAGES];

    logic [W-1:0]     n_rem [STAGES][LANES];
    logic [FB:0]      n_q   [STAGES][LANES];

    always_comb begin
        logic [W:0] t;
        logic       b;
        for (int l = 0; l < LANES; l++) begin
            // The first stage yields the integer bit of the quotient.
            b = (i_num[l] >= i_den[l]);
            n_rem[0][l] = b ? (i_num[l] - i_den[l]) : i_num[l];
            n_q[0][l]   = {{FB{1'b0}}, b};
            for (int s = 1; s < STAGES; s++) begin
                t = {r_rem[s-1][l], 1'b0};
                b = (t >= {1'b0, r_den[s-1][l]});
                n_rem[s][l] = b ? W'(t - {1'b0, r_den[s-1][l]}) : t[W-1:0];
                n_q[s][l]   = {r_q[s-1][l][FB-1:0], b};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < STAGES; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < STAGES; s++) r_tag[s] <= r_tag[s-1];
            for (int l = 0; l < LANES; l++) begin
                r_den[0][l] <= i_den[l];
                for (int s = 1; s < STAGES; s++) r_den[s][l] <= r_den[s-1][l];
                for (int s = 0; s < STAGES; s++) begin
                    r_rem[s][l] <= n_rem[s][l];
                    r_q[s][l]   <= n_q[s][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) o_quo[l] = r_q[STAGES-1][l];
    end
    assign o_valid = r_v[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];

endmodule
`default_nettype wire

// ===== hw/rtl/crdg_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module crdg_isqrt #(
    parameter int IN_W  = 54,
    parameter int TAG_W = 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [IN_W-1:0]    i_rad,
    input  wire logic [TAG_W-1:0]   i_tag,
    output logic                    o_valid,
    output logic [IN_W/2-1:0]       o_root,
    output logic [TAG_W-1:0]        o_tag
);
    localparam int N  = IN_W / 2;
    localparam int RW = IN_W / 2;

    logic             r_v    [N];
    logic [IN_W-1:0]  r_rad  [N];
    logic [RW+1:0]    r_rem  [N];
    logic [RW-1:0]    r_root [N];
    logic [TAG_W-1:0] r_tag  [N];

    logic [IN_W-1:0]  n_rad  [N];
    logic [RW+1:0]    n_rem  [N];
    logic [RW-1:0]    n_root [N];

    always_comb begin
        logic [IN_W-1:0] p_rad;
        logic [RW+1:0]   p_rem;
        logic [RW-1:0]   p_root;
        logic [RW+1:0]   pre;
        logic [RW+1:0]   trial;
        logic            b;
        for (int s = 0; s < N; s++) begin
            if (s == 0) begin
                p_rad  = i_rad;
                p_rem  = '0;
                p_root = '0;
            end else begin
                p_rad  = r_rad[s-1];
                p_rem  = r_rem[s-1];
                p_root = r_root[s-1];
            end
            // The remainder stays at most twice the partial root, so its top bits are zero.
            pre   = {p_rem[RW-1:0], p_rad[IN_W-1 -: 2]};
            trial = {p_root, 2'b01};
            b     = (pre >= trial);
            n_rem[s]  = b ? (pre - trial) : pre;
            n_root[s] = {p_root[RW-2:0], b};
            n_rad[s]  = {p_rad[IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < N; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < N; s++) r_tag[s] <= r_tag[s-1];
            for (int s = 0; s < N; s++) begin
                r_rad[s]  <= n_rad[s];
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_tag   = r_tag[N-1];

endmodule
`default_nettype wire

// ===== hw/rtl/crdg_combine.sv =====
// Scaling, basis combination and squared length of the ray direction over five stages.
`default_nettype none
module crdg_combine #(
    parameter int DIM_W = 14
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_en,
    input  wire logic                                   i_valid,
    input  wire logic [crdg_pkg::NDC_FB:0]              i_qx,
    input  wire logic [crdg_pkg::NDC_FB:0]              i_qy,
    input  wire logic [crdg_pkg::COORD_W-1:0]           i_px,
    input  wire logic [crdg_pkg::COORD_W-1:0]           i_py,
    input  wire logic [DIM_W-1:0]                       i_width,
    input  wire logic [crdg_pkg::SCALE_W-1:0]           i_hscale,
    input  wire logic [crdg_pkg::SCALE_W-1:0]           i_vscale,
    input  wire logic [crdg_pkg::VEC_W-1:0]             i_right,
    input  wire logic [crdg_pkg::VEC_W-1:0]             i_up,
    input  wire logic [crdg_pkg::VEC_W-1:0]             i_forward,
    output logic                                        o_valid,
    output logic [crdg_pkg::SUM_W-1:0]                  o_sum,
    output logic [2:0][crdg_pkg::MAG_W-1:0]             o_mag,
    output logic [2:0]                                  o_neg,
    output logic [crdg_pkg::IDX_W-1:0]                  o_idx
);
    localparam int CW = crdg_pkg::COMP_W;
    localparam int IW = crdg_pkg::IDX_W;

    logic r_v [5];
    logic [IW-1:0] r_idx [5];

    // Stage 1: map to [-1,1) and scale.
    logic signed [18:0] nx, ny;
    logic signed [39:0] prod_x, prod_y;
    logic [27:0]        idx_full;
    logic signed [crdg_pkg::UV_W-1:0] r_u, r_v_s;

    assign nx = $signed({2'b00, i_qx[crdg_pkg::NDC_FB-1:0]}) - 19'sd65536;
    assign ny = $signed({2'b00, i_qy[crdg_pkg::NDC_FB-1:0]}) - 19'sd65536;
    assign prod_x = nx * $signed({1'b0, i_hscale});
    assign prod_y = ny * $signed({1'b0, i_vscale});
    assign idx_full = 28'(i_px) + 28'(i_py) * 28'(i_width);

    // Stage 2: axis products.
    logic signed [crdg_pkg::PROD_W-1:0] r_pr [3];
    logic signed [crdg_pkg::PROD_W-1:0] r_pu [3];
    // Stage 3: combined direction.
    logic signed [crdg_pkg::D_W-1:0]    r_d  [3];
    logic signed [crdg_pkg::D_W-1:0]    n_d  [3];
    // Stage 4: magnitudes and squares.
    logic [crdg_pkg::MAG_W-1:0]         r_mag4 [3];
    logic [crdg_pkg::MAG_W-1:0]         n_mag  [3];
    logic [crdg_pkg::SUM_W-1:0]         n_sq   [3];
    logic [crdg_pkg::SUM_W-1:0]         r_sq   [3];
    logic [2:0]                         r_neg4;
    // Stage 5: sum of squares.
    logic [crdg_pkg::SUM_W-1:0]         r_sum;
    logic [crdg_pkg::MAG_W-1:0]         r_mag5 [3];
    logic [2:0]                         r_neg5;

    always_comb begin
        logic signed [44:0] acc;
        logic signed [CW-1:0] f;
        for (int c = 0; c < 3; c++) begin
            f   = $signed(i_forward[CW*c +: CW]);
            acc = 45'(r_pr[c]) + 45'(r_pu[c]) + (45'(f) <<< 16);
            n_d[c]   = acc[43:16];
            n_mag[c] = r_d[c][crdg_pkg::D_W-1] ? crdg_pkg::MAG_W'(-r_d[c])
                                                : crdg_pkg::MAG_W'(r_d[c]);
            n_sq[c]  = n_mag[c] * n_mag[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < 5; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u      <= prod_x[37:16];
            r_v_s    <= prod_y[37:16];
            r_idx[0] <= idx_full[IW-1:0];
            for (int s = 1; s < 5; s++) r_idx[s] <= r_idx[s-1];
            for (int c = 0; c < 3; c++) begin
                r_pr[c]   <= r_u   * $signed(i_right[CW*c +: CW]);
                r_pu[c]   <= r_v_s * $signed(i_up[CW*c +: CW]);
                r_d[c]    <= n_d[c];
                r_neg4[c] <= r_d[c][crdg_pkg::D_W-1];
                r_mag4[c] <= n_mag[c];
                r_sq[c]   <= n_sq[c];
                r_mag5[c] <= r_mag4[c];
            end
            r_neg5 <= r_neg4;
            r_sum  <= r_sq[0] + r_sq[1] + r_sq[2];
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) o_mag[c] = r_mag5[c];
    end
    assign o_valid = r_v[4];
    assign o_sum   = r_sum;
    assign o_neg   = r_neg5;
    assign o_idx   = r_idx[4];

endmodule
`default_nettype wire

// ===== hw/rtl/camera_ray_direction_generator.sv =====
// Top level of the pinhole camera primary ray generator.
//
//  channel  direction  content
//  s        in         tdata: pixel_x [12:0], pixel_y [25:13]
//  m        out        tdata: pixel_index, dir_x, dir_y, dir_z, origin_x, origin_y, origin_z
//  cfg      in         write enable, register index, 63-bit data
//
// One item per clock is taken and one result per clock given while the output is not held;
// the pipeline holds the input register, 18 coordinate divider stages, 5 combine stages,
// 27 square root stages, 17 normalize divider stages and the output register.
// Reset clears all valid bits and loads the default camera; no clearing pass is needed.
// All stages move together; a two-entry output buffer keeps the pipeline running while
// one result waits, and input is held off only when both entries are full.
`default_nettype none
module camera_ray_direction_generator #(
    parameter int MAX_DIMENSION = crdg_pkg::DEF_MAX_DIMENSION
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // pixel_x [12:0], pixel_y [25:13], zeros above
    input  wire logic [crdg_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // pixel_index [25:0], dir_x [43:26], dir_y [61:44], dir_z [79:62],
    // origin_x [100:80], origin_y [121:101], origin_z [142:122], zero [143]
    output logic [crdg_pkg::OUT_DATA_W-1:0]         o_m_tdata,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [crdg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [crdg_pkg::VEC_W-1:0]         i_cfg_data
);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CW    = crdg_pkg::COORD_W;
    localparam int RES_W = crdg_pkg::IDX_W + 3 * crdg_pkg::DIR_W;

    // Configuration registers.
    logic [crdg_pkg::SIZE_W-1:0]  r_width, r_height;
    logic [crdg_pkg::SCALE_W-1:0] r_hscale, r_vscale;
    logic [crdg_pkg::VEC_W-1:0]   r_right, r_up, r_forward, r_camera;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= crdg_pkg::RST_WIDTH;
            r_height  <= crdg_pkg::RST_HEIGHT;
            r_hscale  <= crdg_pkg::RST_HSCALE;
            r_vscale  <= crdg_pkg::RST_VSCALE;
            r_right   <= crdg_pkg::RST_RIGHT;
            r_up      <= crdg_pkg::RST_UP;
            r_forward <= crdg_pkg::RST_FORWARD;
            r_camera  <= crdg_pkg::RST_CAMERA;
        end else if (i_cfg_wr_en) begin
            case (crdg_pkg::t_cfg_reg'(i_cfg_index))
                crdg_pkg::REG_SURFACE_WIDTH:    r_width   <= i_cfg_data[crdg_pkg::SIZE_W-1:0];
                crdg_pkg::REG_SURFACE_HEIGHT:   r_height  <= i_cfg_data[crdg_pkg::SIZE_W-1:0];
                crdg_pkg::REG_HORIZONTAL_SCALE: r_hscale  <= i_cfg_data[crdg_pkg::SCALE_W-1:0];
                crdg_pkg::REG_VERTICAL_SCALE:   r_vscale  <= i_cfg_data[crdg_pkg::SCALE_W-1:0];
                crdg_pkg::REG_RIGHT_AXIS:       r_right   <= i_cfg_data;
                crdg_pkg::REG_UP_AXIS:          r_up      <= i_cfg_data;
                crdg_pkg::REG_FORWARD_AXIS:     r_forward <= i_cfg_data;
                crdg_pkg::REG_CAMERA_POSITION:  r_camera  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective surface size: zero acts as one, oversize is cut to the maximum.
    logic [DIM_W-1:0] eff_w, eff_h;
    always_comb begin
        if (r_width == '0)                                 eff_w = DIM_W'(1);
        else if ({1'b0, r_width} > 15'(MAX_DIMENSION))     eff_w = DIM_W'(MAX_DIMENSION);
        else                                               eff_w = DIM_W'(r_width);
        if (r_height == '0)                                eff_h = DIM_W'(1);
        else if ({1'b0, r_height} > 15'(MAX_DIMENSION))    eff_h = DIM_W'(MAX_DIMENSION);
        else                                               eff_h = DIM_W'(r_height);
    end

    logic en;
    logic r_sk_v, r_out_v;
    assign en         = !r_sk_v;
    assign o_s_tready = en;

    // Input stage: clamp the coordinate into the surface.
    logic [CW-1:0]    in_px, in_py, n_px, n_py, r_px, r_py;
    logic [DIM_W-1:0] lim_w, lim_h;
    logic             r_s0_v;
    assign in_px = i_s_tdata[CW-1:0];
    assign in_py = i_s_tdata[2*CW-1:CW];
    assign lim_w = eff_w - DIM_W'(1);
    assign lim_h = eff_h - DIM_W'(1);
    assign n_px  = ({2'b00, in_px} > 15'(lim_w)) ? CW'(lim_w) : in_px;
    assign n_py  = ({2'b00, in_py} > 15'(lim_h)) ? CW'(lim_h) : in_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_s0_v <= 1'b0;
        else if (en)   r_s0_v <= i_s_tvalid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px <= n_px;
            r_py <= n_py;
        end
    end

    // Coordinate divider: p * 2^17 / size.
    logic                              ndc_v;
    logic [1:0][crdg_pkg::NDC_FB:0]    ndc_q;
    logic [2*CW-1:0]                   ndc_tag;

    crdg_div_pipe #(
        .LANES (2),
        .W     (DIM_W),
        .FB    (crdg_pkg::NDC_FB),
        .TAG_W (2 * CW)
    ) u_ndc_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s0_v),
        .i_num   ({DIM_W'(r_py), DIM_W'(r_px)}),
        .i_den   ({eff_h, eff_w}),
        .i_tag   ({r_py, r_px}),
        .o_valid (ndc_v),
        .o_quo   (ndc_q),
        .o_tag   (ndc_tag)
    );

    logic                                   cmb_v;
    logic [crdg_pkg::SUM_W-1:0]             cmb_sum;
    logic [2:0][crdg_pkg::MAG_W-1:0]        cmb_mag;
    logic [2:0]                             cmb_neg;
    logic [crdg_pkg::IDX_W-1:0]             cmb_idx;

    crdg_combine #(
        .DIM_W (DIM_W)
    ) u_combine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (ndc_v),
        .i_qx      (ndc_q[0]),
        .i_qy      (ndc_q[1]),
        .i_px      (ndc_tag[CW-1:0]),
        .i_py      (ndc_tag[2*CW-1:CW]),
        .i_width   (eff_w),
        .i_hscale  (r_hscale),
        .i_vscale  (r_vscale),
        .i_right   (r_right),
        .i_up      (r_up),
        .i_forward (r_forward),
        .o_valid   (cmb_v),
        .o_sum     (cmb_sum),
        .o_mag     (cmb_mag),
        .o_neg     (cmb_neg),
        .o_idx     (cmb_idx)
    );

    localparam int SQ_TAG_W = 3 + 3 * crdg_pkg::MAG_W + crdg_pkg::IDX_W;

    logic                          sq_v;
    logic [crdg_pkg::ROOT_W-1:0]   sq_root;
    logic [SQ_TAG_W-1:0]           sq_tag;

    crdg_isqrt #(
        .IN_W  (crdg_pkg::SUM_W),
        .TAG_W (SQ_TAG_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cmb_v),
        .i_rad   (cmb_sum),
        .i_tag   ({cmb_neg, cmb_mag, cmb_idx}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    // Normalize: each magnitude is at most the length, so the quotient is at most 1.0.
    localparam int NV_TAG_W = 4 + crdg_pkg::IDX_W;

    logic [2:0][crdg_pkg::MAG_W-1:0] sq_mag;
    logic                            nv_v;
    logic [2:0][crdg_pkg::DIR_FB:0]  nv_q;
    logic [NV_TAG_W-1:0]             nv_tag;

    assign sq_mag = sq_tag[crdg_pkg::IDX_W +: 3 * crdg_pkg::MAG_W];

    crdg_div_pipe #(
        .LANES (3),
        .W     (crdg_pkg::MAG_W),
        .FB    (crdg_pkg::DIR_FB),
        .TAG_W (NV_TAG_W)
    ) u_norm_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_v),
        .i_num   (sq_mag),
        .i_den   ({3{sq_root}}),
        .i_tag   ({sq_root == '0, sq_tag[SQ_TAG_W-1 -: 3], sq_tag[crdg_pkg::IDX_W-1:0]}),
        .o_valid (nv_v),
        .o_quo   (nv_q),
        .o_tag   (nv_tag)
    );

    // Apply sign, and zero the direction when the length is zero.
    logic [RES_W-1:0] res;
    always_comb begin
        logic [crdg_pkg::DIR_W-1:0] mag;
        res[crdg_pkg::IDX_W-1:0] = nv_tag[crdg_pkg::IDX_W-1:0];
        for (int c = 0; c < 3; c++) begin
            mag = {1'b0, nv_q[c]};
            if (nv_tag[NV_TAG_W-1])
                res[crdg_pkg::IDX_W + crdg_pkg::DIR_W*c +: crdg_pkg::DIR_W] = '0;
            else if (nv_tag[crdg_pkg::IDX_W + c])
                res[crdg_pkg::IDX_W + crdg_pkg::DIR_W*c +: crdg_pkg::DIR_W] = -mag;
            else
                res[crdg_pkg::IDX_W + crdg_pkg::DIR_W*c +: crdg_pkg::DIR_W] = mag;
        end
    end

    // Two-entry output buffer.
    logic [RES_W-1:0] r_out_d, r_sk_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end else begin
                r_out_v <= nv_v;
            end
        end else if (nv_v && !r_sk_v) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out_d <= r_sk_v ? r_sk_d : res;
        end else if (!r_sk_v) begin
            r_sk_d <= res;
        end
    end

    // Origin is the camera position; user must hold it while items are in flight, unenforced.
    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {1'b0, r_camera, r_out_d};

    // The spill entry is only ever occupied behind a held output entry.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_v |-> r_out_v)
        else $error("spill entry full while output entry empty");

    // A result that leaves the pipeline while the output is held must land in the spill entry.
    a_spill_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (nv_v && en && r_out_v && !i_m_tready) |=> r_sk_v)
        else $error("result lost at a held output");

    // A unit direction never has a component beyond one.
    a_dir_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ($signed(r_out_d[43:26]) <= 18'sd65536 &&
                     $signed(r_out_d[43:26]) >= -18'sd65536 &&
                     $signed(r_out_d[61:44]) <= 18'sd65536 &&
                     $signed(r_out_d[61:44]) >= -18'sd65536 &&
                     $signed(r_out_d[79:62]) <= 18'sd65536 &&
                     $signed(r_out_d[79:62]) >= -18'sd65536))
        else $error("direction component out of range");

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the camera ray direction generator.
`default_nettype none
module tb;

    typedef struct {
        logic [crdg_pkg::IDX_W-1:0]  pixel_index;
        logic [crdg_pkg::DIR_W-1:0]  dir [3];
        logic [crdg_pkg::COMP_W-1:0] origin [3];
    } t_ray;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [crdg_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [crdg_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            i_cfg_wr_en = 1'b0;
    logic [crdg_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [crdg_pkg::VEC_W-1:0]      i_cfg_data = '0;

    camera_ray_direction_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the camera registers.
    logic [crdg_pkg::SIZE_W-1:0]  cam_width, cam_height;
    logic [crdg_pkg::SCALE_W-1:0] cam_hscale, cam_vscale;
    logic [crdg_pkg::VEC_W-1:0]   cam_right, cam_up, cam_forward, cam_position;

    t_ray        pending_rays[$];
    int unsigned mismatches = 0;
    int unsigned rays_seen = 0;
    int unsigned pixels_sent = 0;
    int unsigned degenerate_rays = 0;
    int unsigned cycles = 0;
    bit          dense_mode = 1'b0;

    function automatic longint comp21(logic [crdg_pkg::VEC_W-1:0] packed_vec, int k);
        logic [crdg_pkg::COMP_W-1:0] f;
        longint                      v;
        f = packed_vec[crdg_pkg::COMP_W*k +: crdg_pkg::COMP_W];
        v = $signed(f);
        return v;
    endfunction

    function automatic longint clip_size(logic [crdg_pkg::SIZE_W-1:0] s);
        if (s == 0) return 1;
        if (s > crdg_pkg::DEF_MAX_DIMENSION) return crdg_pkg::DEF_MAX_DIMENSION;
        return s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic t_ray trace_pixel(longint px, longint py);
        t_ray   r;
        longint w, h, u, v, acc, len, m, q, sum;
        longint d [3];
        w = clip_size(cam_width);
        h = clip_size(cam_height);
        if (px > w - 1) px = w - 1;
        if (py > h - 1) py = h - 1;
        // Arithmetic right shift of a signed value gives floor division.
        u = ((((px << 17) / w) - 65536) * longint'(cam_hscale)) >>> 16;
        v = ((((py << 17) / h) - 65536) * longint'(cam_vscale)) >>> 16;
        sum = 0;
        for (int k = 0; k < 3; k++) begin
            acc = u * comp21(cam_right, k) + v * comp21(cam_up, k)
                + comp21(cam_forward, k) * 65536;
            d[k] = acc >>> 16;
            sum += d[k] * d[k];
        end
        len = int_sqrt(longint'(sum));
        r.pixel_index = crdg_pkg::IDX_W'(px + py * w);
        for (int k = 0; k < 3; k++) begin
            q = 0;
            if (len != 0) begin
                m = d[k] < 0 ? -d[k] : d[k];
                q = (m << 16) / len;
                if (d[k] < 0) q = -q;
            end
            r.dir[k] = crdg_pkg::DIR_W'(q);
            r.origin[k] = cam_position[crdg_pkg::COMP_W*k +: crdg_pkg::COMP_W];
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (dense_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(logic [crdg_pkg::COORD_W-1:0] px,
                              logic [crdg_pkg::COORD_W-1:0] py);
        int   gap;
        t_ray r;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tdata = {6'b0, py, px};
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        r = trace_pixel(px, py);
        if (r.dir[0] == 0 && r.dir[1] == 0 && r.dir[2] == 0) degenerate_rays++;
        pending_rays.push_back(r);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending_rays.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Written only with the pipeline empty.
    task automatic write_reg(crdg_pkg::t_cfg_reg idx, logic [crdg_pkg::VEC_W-1:0] value);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            crdg_pkg::REG_SURFACE_WIDTH:    cam_width = value[crdg_pkg::SIZE_W-1:0];
            crdg_pkg::REG_SURFACE_HEIGHT:   cam_height = value[crdg_pkg::SIZE_W-1:0];
            crdg_pkg::REG_HORIZONTAL_SCALE: cam_hscale = value[crdg_pkg::SCALE_W-1:0];
            crdg_pkg::REG_VERTICAL_SCALE:   cam_vscale = value[crdg_pkg::SCALE_W-1:0];
            crdg_pkg::REG_RIGHT_AXIS:       cam_right = value;
            crdg_pkg::REG_UP_AXIS:          cam_up = value;
            crdg_pkg::REG_FORWARD_AXIS:     cam_forward = value;
            crdg_pkg::REG_CAMERA_POSITION:  cam_position = value;
            default: ;
        endcase
    endtask

    function automatic logic [crdg_pkg::VEC_W-1:0] rand_vec();
        return crdg_pkg::VEC_W'({$urandom(), $urandom()});
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_ray want;
        logic [crdg_pkg::IDX_W-1:0] got_idx;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rays_seen++;
            got_idx = o_m_tdata[25:0];
            if (pending_rays.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected ray, index %0d", got_idx);
            end else begin
                want = pending_rays.pop_front();
                if (got_idx !== want.pixel_index
                        || o_m_tdata[43:26] !== want.dir[0]
                        || o_m_tdata[61:44] !== want.dir[1]
                        || o_m_tdata[79:62] !== want.dir[2]
                        || o_m_tdata[100:80] !== want.origin[0]
                        || o_m_tdata[121:101] !== want.origin[1]
                        || o_m_tdata[142:122] !== want.origin[2]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ray mismatch: exp idx %0d dir %h %h %h org %h %h %h",
                            want.pixel_index, want.dir[0], want.dir[1], want.dir[2],
                            want.origin[0], want.origin[1], want.origin[2]);
                        $display("              got idx %0d dir %h %h %h org %h %h %h",
                            got_idx, o_m_tdata[43:26], o_m_tdata[61:44], o_m_tdata[79:62],
                            o_m_tdata[100:80], o_m_tdata[121:101], o_m_tdata[142:122]);
                    end
                end
            end
        end
    end

    // Receiver back-pressure: mostly ready, with short and occasional long stalls; no new stalls in dense mode.
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (!dense_mode && $urandom_range(0, 99) < 15) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 3);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 1000000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_default_camera();
        send_pixel(0, 0);
        send_pixel(1279, 719);
        send_pixel(640, 360);
        send_pixel(13'h1FFF, 13'h1FFF);
        send_pixel(1300, 5);
        send_pixel(5, 800);
        drain();
    endtask

    task automatic test_surface_extremes();
        write_reg(crdg_pkg::REG_SURFACE_WIDTH, 0);
        write_reg(crdg_pkg::REG_SURFACE_HEIGHT, 0);
        send_pixel(0, 0);
        send_pixel(13'h1FFF, 13'h0AAA);
        drain();
        write_reg(crdg_pkg::REG_SURFACE_WIDTH, 14'h3FFF);
        write_reg(crdg_pkg::REG_SURFACE_HEIGHT, 8192);
        send_pixel(0, 8191);
        send_pixel(8191, 0);
        send_pixel(4096, 4096);
        drain();
        write_reg(crdg_pkg::REG_SURFACE_WIDTH, 8193);
        write_reg(crdg_pkg::REG_SURFACE_HEIGHT, 1);
        send_pixel(8191, 8191);
        drain();
    endtask

    task automatic test_scale_and_axes();
        write_reg(crdg_pkg::REG_HORIZONTAL_SCALE, 20'hFFFFF);
        write_reg(crdg_pkg::REG_VERTICAL_SCALE, 0);
        write_reg(crdg_pkg::REG_CAMERA_POSITION, {3{21'h100000}});
        send_pixel(0, 0);
        send_pixel(8191, 8191);
        drain();
        // All axes zero leaves no direction to normalize.
        write_reg(crdg_pkg::REG_RIGHT_AXIS, 0);
        write_reg(crdg_pkg::REG_UP_AXIS, 0);
        write_reg(crdg_pkg::REG_FORWARD_AXIS, 0);
        write_reg(crdg_pkg::REG_CAMERA_POSITION, {3{21'h0FFFFF}});
        send_pixel(100, 100);
        drain();
        write_reg(crdg_pkg::REG_RIGHT_AXIS, {3{21'h0FFFFF}});
        write_reg(crdg_pkg::REG_UP_AXIS, {3{21'h100000}});
        write_reg(crdg_pkg::REG_FORWARD_AXIS, {3{21'h0FFFFF}});
        write_reg(crdg_pkg::REG_VERTICAL_SCALE, 20'hFFFFF);
        send_pixel(0, 0);
        send_pixel(8191, 8191);
        send_pixel(0, 8191);
        drain();
    endtask

    task automatic test_random_cameras();
        logic [crdg_pkg::SIZE_W-1:0] w, h;
        for (int phase = 0; phase < 10; phase++) begin
            dense_mode = (phase % 4 == 3);
            case ($urandom_range(0, 3))
                0: begin
                    w = crdg_pkg::SIZE_W'($urandom_range(0, 16383));
                    h = crdg_pkg::SIZE_W'($urandom_range(0, 16383));
                end
                default: begin
                    w = crdg_pkg::SIZE_W'($urandom_range(1, 64));
                    h = crdg_pkg::SIZE_W'($urandom_range(1, 64));
                end
            endcase
            write_reg(crdg_pkg::REG_SURFACE_WIDTH,
                      rand_vec() & ~crdg_pkg::VEC_W'(14'h3FFF) | crdg_pkg::VEC_W'(w));
            write_reg(crdg_pkg::REG_SURFACE_HEIGHT,
                      rand_vec() & ~crdg_pkg::VEC_W'(14'h3FFF) | crdg_pkg::VEC_W'(h));
            write_reg(crdg_pkg::REG_HORIZONTAL_SCALE, rand_vec());
            write_reg(crdg_pkg::REG_VERTICAL_SCALE, rand_vec());
            write_reg(crdg_pkg::REG_RIGHT_AXIS, rand_vec());
            write_reg(crdg_pkg::REG_UP_AXIS, rand_vec());
            write_reg(crdg_pkg::REG_FORWARD_AXIS, rand_vec());
            write_reg(crdg_pkg::REG_CAMERA_POSITION, rand_vec());
            for (int n = 0; n < 112; n++) begin
                if ($urandom_range(0, 3) == 0)
                    send_pixel(crdg_pkg::COORD_W'($urandom()),
                               crdg_pkg::COORD_W'($urandom()));
                else
                    send_pixel(crdg_pkg::COORD_W'($urandom_range(0, clip_size(w) - 1)),
                               crdg_pkg::COORD_W'($urandom_range(0, clip_size(h) - 1)));
            end
            dense_mode = 1'b0;
            drain();
        end
    endtask

    initial begin
        cam_width = crdg_pkg::RST_WIDTH;
        cam_height = crdg_pkg::RST_HEIGHT;
        cam_hscale = crdg_pkg::RST_HSCALE;
        cam_vscale = crdg_pkg::RST_VSCALE;
        cam_right = crdg_pkg::RST_RIGHT;
        cam_up = crdg_pkg::RST_UP;
        cam_forward = crdg_pkg::RST_FORWARD;
        cam_position = crdg_pkg::RST_CAMERA;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_default_camera();
        test_surface_extremes();
        test_scale_and_axes();
        test_random_cameras();
        repeat (80) @(posedge i_clk);
        $display("Sent %0d pixels over default, extreme and random cameras.", pixels_sent);
        $display("Checked %0d rays, %0d with zero direction; %0d mismatches.",
                 rays_seen, degenerate_rays, mismatches);
        if (mismatches == 0 && pending_rays.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
